### hw/rtl/bacfp_pkg.sv
// ----------------------------------------------------------------------------
// bacfp_pkg
// Shared types and constants for the fixed-probability binary arithmetic
// codec: item and result payloads, and the controller/datapath link.
// ----------------------------------------------------------------------------
package bacfp_pkg;

	// Fraction width of the interval arithmetic; 1.0 is 2^FRAC_BITS.
	localparam int unsigned FRAC_BITS = 32;
	localparam int unsigned RANGE_W   = FRAC_BITS + 1;
	localparam logic [RANGE_W-1:0] ONE_POINT_ZERO = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [RANGE_W-1:0] MIN_RANGE      = RANGE_W'(4);

	// Item kinds.
	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// One input item.
	typedef struct packed {
		logic       kind;
		logic       bit_in;
		logic       is_last;
		logic [3:0] symbol_count;
	} item_t;

	// One result item.
	typedef struct packed {
		logic bit_out;
		logic last_out;
		logic overflow;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // apply the accepted item to encoder or decoder state
		logic dec_start;  // load symbol count and restart the decode interval
		logic dec_clear;  // empty decode message: clear the code register
		logic norm_init;  // load the leading-zero search from the range
		logic norm_shift; // one step of the leading-zero search
		logic round;      // form the rounded code word
		logic enc_emit;   // emit one code bit
		logic dec_emit;   // emit one decoded symbol
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic norm_done; // leading-zero search has reached the top bit
		logic cnt_last;  // the next emitted result is the final one
		logic out_free;  // output register can take a result this cycle
	} dp_status_t;

endpackage

### hw/rtl/bacfp_datapath.sv
// ----------------------------------------------------------------------------
// bacfp_datapath
// Interval registers, code register, leading-zero search, rounding and the
// output register of the codec. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module bacfp_datapath
	import bacfp_pkg::*;
#(
	parameter int unsigned MAX_SYMBOLS = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result
);

	localparam logic [3:0] MAX_SYM = 4'(MAX_SYMBOLS);

	// Encoder state.
	logic [FRAC_BITS-1:0] enc_low_q;
	logic [RANGE_W-1:0]   enc_range_q;
	logic [3:0]           symbols_seen_q;
	logic                 overflow_flag_q;

	// Decoder state.
	logic [FRAC_BITS-1:0] code_value_q;
	logic [5:0]           code_bits_seen_q;
	logic [RANGE_W-1:0]   dec_low_q;
	logic [RANGE_W-1:0]   dec_range_q;
	logic                 dec_ovf_q;

	// Message-end working registers.
	logic [RANGE_W-1:0]   norm_q;
	logic [FRAC_BITS-1:0] mask_q;
	logic [FRAC_BITS-1:0] word_q;
	logic [4:0]           cnt_q;

	// Output register.
	logic    res_valid_q;
	result_t res_q;

	logic [RANGE_W-1:0]   enc_quarter;
	logic [RANGE_W-1:0]   norm_src;
	logic [FRAC_BITS-1:0] keep_bits;
	logic [FRAC_BITS-1:0] round_unit;
	logic [RANGE_W-1:0]   dec_quarter;
	logic [RANGE_W-1:0]   dec_split;
	logic                 dec_bit;
	logic [3:0]           dec_count;

	// Interval splits and rounding terms.
	always_comb begin
		enc_quarter = enc_range_q >> 2;
		norm_src    = (enc_range_q < MIN_RANGE) ? MIN_RANGE : enc_range_q;
		keep_bits   = enc_low_q & ~mask_q;
		round_unit  = (|(enc_low_q & mask_q)) ? (mask_q + FRAC_BITS'(1)) : '0;
		dec_quarter = dec_range_q >> 2;
		dec_split   = dec_low_q + dec_quarter;
		dec_bit     = !(dec_split > {1'b0, code_value_q});
		dec_count   = (item.symbol_count > MAX_SYM) ? MAX_SYM : item.symbol_count;
	end

	// Status back to the controller.
	always_comb begin
		status.norm_done = norm_q[RANGE_W-1];
		status.cnt_last  = (cnt_q == 5'd1);
		status.out_free  = !res_valid_q || !result_stall;
	end

	// Encoder interval and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_low_q       <= '0;
			enc_range_q     <= ONE_POINT_ZERO;
			symbols_seen_q  <= '0;
			overflow_flag_q <= 1'b0;
		end else if (cmd.enc_emit && status.cnt_last) begin
			enc_low_q       <= '0;
			enc_range_q     <= ONE_POINT_ZERO;
			symbols_seen_q  <= '0;
			overflow_flag_q <= 1'b0;
		end else if (cmd.accept && item.kind == KIND_ENCODE) begin
			if (symbols_seen_q >= MAX_SYM) begin
				overflow_flag_q <= 1'b1;
			end else begin
				if (item.bit_in) begin
					enc_low_q   <= enc_low_q + enc_quarter[FRAC_BITS-1:0];
					enc_range_q <= enc_range_q - enc_quarter;
				end else begin
					enc_range_q <= enc_quarter;
				end
				symbols_seen_q <= symbols_seen_q + 4'd1;
			end
		end
	end

	// Code register: bits fill from the top, later than the 32nd are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_value_q     <= '0;
			code_bits_seen_q <= '0;
		end else if (cmd.dec_clear || (cmd.dec_emit && status.cnt_last)) begin
			code_value_q     <= '0;
			code_bits_seen_q <= '0;
		end else if (cmd.accept && item.kind == KIND_DECODE && !code_bits_seen_q[5]) begin
			code_value_q[~code_bits_seen_q[4:0]] <= item.bit_in;
			code_bits_seen_q                     <= code_bits_seen_q + 6'd1;
		end
	end

	// Decode interval, restarted at [0, 1) for each message.
	always_ff @(posedge clk) begin
		if (cmd.dec_start) begin
			dec_low_q   <= '0;
			dec_range_q <= ONE_POINT_ZERO;
			dec_ovf_q   <= (item.symbol_count > MAX_SYM);
		end else if (cmd.dec_emit) begin
			if (dec_bit) begin
				dec_low_q   <= dec_split;
				dec_range_q <= dec_range_q - dec_quarter;
			end else begin
				dec_range_q <= dec_quarter;
			end
		end
	end

	// Leading-zero search of range - 1 and the rounded code word. The count of
	// leading zeros is the code length; the mask tracks the discarded bits.
	always_ff @(posedge clk) begin
		if (cmd.norm_init) begin
			norm_q <= norm_src - RANGE_W'(1);
			mask_q <= '1;
		end else if (cmd.norm_shift) begin
			norm_q <= norm_q << 1;
			mask_q <= mask_q >> 1;
		end
		if (cmd.round) begin
			word_q <= keep_bits + round_unit;
		end else if (cmd.enc_emit) begin
			word_q <= word_q << 1;
		end
	end

	// Shared counter: code length during the search, then results left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.norm_init) begin
			cnt_q <= '0;
		end else if (cmd.norm_shift) begin
			cnt_q <= cnt_q + 5'd1;
		end else if (cmd.dec_start) begin
			cnt_q <= {1'b0, dec_count};
		end else if (cmd.enc_emit || cmd.dec_emit) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	// Output register: holds a result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.enc_emit || cmd.dec_emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.enc_emit) begin
			res_q.bit_out  <= word_q[FRAC_BITS-1];
			res_q.last_out <= status.cnt_last;
			res_q.overflow <= overflow_flag_q;
		end else if (cmd.dec_emit) begin
			res_q.bit_out  <= dec_bit;
			res_q.last_out <= status.cnt_last;
			res_q.overflow <= dec_ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// A result is only loaded when the output register is free.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.enc_emit || cmd.dec_emit) |-> status.out_free)
		else $error("result loaded over a pending result");

	// Emission never runs with an empty result count.
	a_emit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.enc_emit || cmd.dec_emit) |-> (cnt_q != 5'd0))
		else $error("emission with zero results left");

	// The leading-zero search ends within the code length limit.
	a_norm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.norm_shift |-> (cnt_q < 5'd31))
		else $error("leading-zero search ran past 31 bits");

	// The decode interval never collapses while symbols are produced.
	a_dec_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec_emit |-> (dec_range_q != '0))
		else $error("decode range collapsed");

endmodule

### hw/rtl/bacfp_ctrl.sv
// ----------------------------------------------------------------------------
// bacfp_ctrl
// Controller of the codec: takes items while idle and sequences the
// message-end work of the encoder and the decoder.
// ----------------------------------------------------------------------------
module bacfp_ctrl
	import bacfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ENC_INIT,
		ST_ENC_NORM,
		ST_ENC_ROUND,
		ST_ENC_EMIT,
		ST_DEC_EMIT
	} state_t;

	state_t state_q;
	logic   take;

	assign item_stall = (state_q != ST_IDLE);
	assign take       = item_valid && (state_q == ST_IDLE);

	// Commands decoded from the state and the accepted item.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = take;
				if (take && item.kind == KIND_DECODE && item.is_last) begin
					cmd.dec_clear = (item.symbol_count == 4'd0);
					cmd.dec_start = (item.symbol_count != 4'd0);
				end
			end
			ST_ENC_INIT:  cmd.norm_init  = 1'b1;
			ST_ENC_NORM:  cmd.norm_shift = !status.norm_done;
			ST_ENC_ROUND: cmd.round      = 1'b1;
			ST_ENC_EMIT:  cmd.enc_emit   = status.out_free;
			ST_DEC_EMIT:  cmd.dec_emit   = status.out_free;
			default:      cmd = '0;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take && item.is_last) begin
						if (item.kind == KIND_ENCODE) begin
							state_q <= ST_ENC_INIT;
						end else if (item.symbol_count != 4'd0) begin
							state_q <= ST_DEC_EMIT;
						end
					end
				end
				ST_ENC_INIT: state_q <= ST_ENC_NORM;
				ST_ENC_NORM: begin
					if (status.norm_done) begin
						state_q <= ST_ENC_ROUND;
					end
				end
				ST_ENC_ROUND: state_q <= ST_ENC_EMIT;
				ST_ENC_EMIT, ST_DEC_EMIT: begin
					if (status.out_free && status.cnt_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/binary_arith_codec_fixed_prob_core.sv
// ----------------------------------------------------------------------------
// binary_arith_codec_fixed_prob_core
// Binary arithmetic encoder and decoder with a static model, P(0) = 1/4.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while the codec is idle; an encode symbol
// narrows the 33-bit interval in the cycle it is taken. The last encode item
// starts the message-end sequence: a setup step, a leading-zero search of
// range - 1 at one bit per cycle, a rounding step and then the L code bits
// (L from 1 to 31), one per cycle while the result side does not stall. The
// last decode item with a count of n (capped at MAX_SYMBOLS) produces n
// symbols, one per cycle while the result side does not stall, each from one
// add and compare in the decode interval. Results leave through a single
// output register, so a stall on the result side holds the sequence; input is
// stalled until the final result of a message has been loaded.
// ----------------------------------------------------------------------------
module binary_arith_codec_fixed_prob_core
	import bacfp_pkg::*;
#(
	parameter int unsigned MAX_SYMBOLS = 15
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencing.
	bacfp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.status     (status),
		.cmd        (cmd)
	);

	// Interval arithmetic and output register.
	bacfp_datapath #(
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### test/tb_binary_arith_codec_fixed_prob_core.sv
// ----------------------------------------------------------------------------
// tb_binary_arith_codec_fixed_prob_core
// Self-checking bench for the fixed-probability arithmetic codec. A
// scoreboard class keeps its own copy of the encoder interval and decoder
// code register. It works out the code bits or decoded symbols for each
// accepted item. The bench checks every result transfer against them in order.
// Stimulus starts with a few hand-picked messages and then runs random
// encode and decode messages with some loose items mixed in. Both sides of
// the block idle at random.
// ----------------------------------------------------------------------------
import bacfp_pkg::*;

class codec_scoreboard #(int unsigned MAX_SYMS = 15);

	logic [31:0] enc_low;
	logic [32:0] enc_range;
	int unsigned enc_symbols;
	logic        enc_dropped;
	logic [31:0] dec_code;
	int unsigned dec_bits;
	result_t     expected_q[$];
	int unsigned errors;

	function new();
		clear_encoder();
		clear_decoder();
		errors = 0;
	endfunction

	function void clear_encoder();
		enc_low     = '0;
		enc_range   = ONE_POINT_ZERO;
		enc_symbols = 0;
		enc_dropped = 1'b0;
	endfunction

	function void clear_decoder();
		dec_code = '0;
		dec_bits = 0;
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction

	// Apply one accepted item and queue the results it causes.
	function void note_item(item_t it);
		logic [32:0] quarter;
		logic [32:0] span;
		logic [32:0] probe;
		logic [63:0] word;
		logic [63:0] rest_mask;
		logic [33:0] dec_low;
		logic [33:0] dec_span;
		logic [33:0] split;
		int unsigned code_len;
		int unsigned shift;
		int unsigned msb;
		int unsigned n;
		logic        too_many;
		result_t     r;

		if (it.kind == KIND_ENCODE) begin
			// A symbol past the limit is dropped, but its end mark still counts.
			if (enc_symbols >= MAX_SYMS) begin
				enc_dropped = 1'b1;
			end else begin
				quarter = enc_range >> 2;
				if (it.bit_in) begin
					enc_low   = enc_low + quarter[31:0];
					enc_range = enc_range - quarter;
				end else begin
					enc_range = quarter;
				end
				enc_symbols++;
			end
			if (it.is_last) begin
				// The code length follows from the ceiling log2 of the range.
				span = (enc_range < MIN_RANGE) ? MIN_RANGE : enc_range;
				msb = 0;
				probe = span;
				while (probe > 33'd1) begin
					probe = probe >> 1;
					msb++;
				end
				if ((span & (span - 33'd1)) != '0)
					msb++;
				code_len = 33 - msb;
				if (code_len < 1)
					code_len = 1;
				if (code_len > 31)
					code_len = 31;
				shift = 32 - code_len;
				word = 64'(enc_low) >> shift;
				rest_mask = (64'd1 << shift) - 64'd1;
				// Round up when low has bits below the code; a carry out wraps.
				if ((64'(enc_low) & rest_mask) != '0)
					word = (word + 64'd1) & ((64'd1 << code_len) - 64'd1);
				for (int unsigned k = 0; k < code_len; k++) begin
					r.bit_out  = word[code_len - 1 - k];
					r.last_out = (k + 1 == code_len);
					r.overflow = enc_dropped;
					expected_q.push_back(r);
				end
				clear_encoder();
			end
		end else begin
			// Code bits after the 32nd cannot change a decision.
			if (dec_bits < 32) begin
				if (it.bit_in)
					dec_code[31 - dec_bits] = 1'b1;
				dec_bits++;
			end
			if (it.is_last) begin
				n = it.symbol_count;
				too_many = 1'b0;
				if (n > MAX_SYMS) begin
					n = MAX_SYMS;
					too_many = 1'b1;
				end
				dec_low  = '0;
				dec_span = 34'(ONE_POINT_ZERO);
				for (int unsigned k = 0; k < n; k++) begin
					split = dec_low + (dec_span >> 2);
					if (split > {2'b00, dec_code}) begin
						r.bit_out = 1'b0;
						dec_span  = dec_span >> 2;
					end else begin
						r.bit_out = 1'b1;
						dec_low   = split;
						dec_span  = dec_span - (dec_span >> 2);
					end
					r.last_out = (k + 1 == n);
					r.overflow = too_many;
					expected_q.push_back(r);
				end
				clear_decoder();
			end
		end
	endfunction

	// Compare one result transfer with the oldest expected result.
	function void check_result(result_t got);
		result_t want;

		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual %b", $time, got);
			return;
		end
		want = expected_q.pop_front();
		if (got.bit_out !== want.bit_out) begin
			errors++;
			$display("%0t: bit_out expected %b actual %b", $time, want.bit_out, got.bit_out);
		end
		if (got.last_out !== want.last_out) begin
			errors++;
			$display("%0t: last_out expected %b actual %b", $time, want.last_out,
				got.last_out);
		end
		if (got.overflow !== want.overflow) begin
			errors++;
			$display("%0t: overflow expected %b actual %b", $time, want.overflow,
				got.overflow);
		end
	endfunction

endclass

module tb_binary_arith_codec_fixed_prob_core;
	import bacfp_pkg::*;

	localparam int unsigned MAX_SYMBOLS  = 15;
	localparam int unsigned ITEM_TARGET  = 450;
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned DRAIN_CYCLES = 100;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_BLOCKY
	} rx_mode_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	codec_scoreboard #(MAX_SYMBOLS) sb;

	int unsigned items_sent    = 0;
	int unsigned burst_left    = 0;
	int unsigned cycle_count   = 0;
	rx_mode_t    rx_mode       = RX_OPEN;
	int unsigned rx_phase_left = 0;

	binary_arith_codec_fixed_prob_core #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	// Clock with a 12-unit period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver stalls on a randomly chosen pattern that changes from phase to phase.
	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_mode       <= rx_mode_t'($urandom_range(0, 3));
			rx_phase_left <= $urandom_range(32, 256);
		end else begin
			rx_phase_left <= rx_phase_left - 1;
		end
		case (rx_mode)
			RX_OPEN: begin
				result_stall <= 1'b0;
			end
			RX_LIGHT: begin
				result_stall <= ($urandom_range(0, 4) == 0);
			end
			RX_HEAVY: begin
				result_stall <= ($urandom_range(0, 9) < 7);
			end
			default: begin
				result_stall <= rx_phase_left[3];
			end
		endcase
	end

	// Watch both channels; values read here are the ones before the edge.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			sb.note_item(item);
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
	end

	function automatic item_t make_item(logic kind, logic bit_val, logic last,
		logic [3:0] count);
		item_t it;

		it.kind         = kind;
		it.bit_in       = bit_val;
		it.is_last      = last;
		it.symbol_count = count;
		return it;
	endfunction

	// Present one item and hold it until the transfer happens. The sender
	// works in bursts with idle gaps in between.
	task automatic send_item(input item_t it);
		int unsigned gap;

		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 20);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	function automatic int unsigned pick_ones_percent();
		case ($urandom_range(0, 4))
			0: return 0;
			1: return 25;
			2: return 50;
			3: return 80;
			default: return 100;
		endcase
	endfunction

	task automatic send_encode_message(input int unsigned len, input int unsigned ones_pct);
		for (int unsigned k = 0; k < len; k++)
			send_item(make_item(KIND_ENCODE, $urandom_range(0, 99) < ones_pct,
				k + 1 == len, 4'($urandom_range(0, 15))));
	endtask

	task automatic send_decode_message(input int unsigned len, input int unsigned ones_pct,
		input logic [3:0] count);
		for (int unsigned k = 0; k < len; k++)
			send_item(make_item(KIND_DECODE, $urandom_range(0, 99) < ones_pct,
				k + 1 == len, (k + 1 == len) ? count : 4'($urandom_range(0, 15))));
	endtask

	initial begin
		int unsigned sel;
		int unsigned len;

		sb = new();
		arst_n       = 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_stall <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sixteen zeros: the smallest range, the longest code and one dropped
		// symbol that sets the overflow flag.
		for (int unsigned k = 0; k < 16; k++)
			send_item(make_item(KIND_ENCODE, 1'b0, k == 15, 4'(k)));
		// Single symbols give the shortest codes, with and without rounding.
		send_item(make_item(KIND_ENCODE, 1'b0, 1'b1, 4'd0));
		send_item(make_item(KIND_ENCODE, 1'b1, 1'b1, 4'd15));
		send_encode_message(3, 100);
		// Largest count, zero count, and an all-zero code.
		send_item(make_item(KIND_DECODE, 1'b1, 1'b1, 4'd15));
		send_item(make_item(KIND_DECODE, 1'b0, 1'b1, 4'd0));
		send_item(make_item(KIND_DECODE, 1'b0, 1'b1, 4'd5));

		// Random messages, mostly well formed, with loose items between them.
		while (items_sent < ITEM_TARGET) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 20)
					: $urandom_range(1, 15);
				send_encode_message(len, pick_ones_percent());
			end else if (sel < 85) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40)
					: $urandom_range(1, 20);
				send_decode_message(len, pick_ones_percent(), 4'($urandom_range(0, 15)));
			end else begin
				send_item(make_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))));
			end
		end
		item_valid <= 1'b0;

		// Let the last results drain, then allow for any trailing activity.
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
